FILE: rtl/tbrl_pkg.sv
// Shared types and constants of the token bucket rate limiter.
package tbrl_pkg;

  localparam int IN_TDATA_W  = 208;
  localparam int OUT_TDATA_W = 8;

  // Refill divide by one second in ns, 1e9 = 2^9 * 5^9: drop the low 9 bits of
  // the product, then multiply by the rounded-up reciprocal of 5^9 scaled by
  // 2^76, which is exact for every 55-bit dividend
  localparam int          PRE_SH     = 9;
  localparam int          Y_W        = 55;
  localparam logic [76:0] FIVE_POW9  = 77'd1953125;
  localparam logic [76:0] RECIP_FULL = ((77'd1 << 76) + FIVE_POW9 - 77'd1) / FIVE_POW9;
  localparam logic [55:0] RECIP      = 56'(RECIP_FULL);

  // Quotient bits kept; the refill of a 64-bit product never reaches 2^35
  localparam int QUO_W      = 36;
  localparam int DIV_CYCLES = 4;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_LOOK,
    S_MUL,
    S_SUM,
    S_DIV,
    S_UPD
  } state_t;

  typedef enum logic [2:0] {
    OUT_CONSUMED = 3'd0,
    OUT_NEW      = 3'd1,
    OUT_DISABLED = 3'd2,
    OUT_EMPTY    = 3'd3,
    OUT_BLOCKED  = 3'd4
  } outcome_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] tokens;
    logic [63:0] last_refill;
    logic [63:0] blocked_until;
  } entry_t;

endpackage

FILE: rtl/token_bucket_rate_limiter_core.sv
// Token bucket policer: bucket table in one synchronous memory, sequenced refill.
//
// Usage: each input beat on in_* names a bucket and carries the packet time, rate,
// burst and block time; one output beat on out_* answers whether to drop the packet
// (limited) and why (outcome). The bucket state (valid, tokens, last refill time,
// block deadline) lives in one memory of NUM_BUCKETS words, read through a register
// the cycle after the address is formed and written back when the decision is made.
// Sequencing: one beat is in work at a time. A beat that is decided at lookup
// (limiting disabled, new bucket, blocked) passes through S_ADDR and S_LOOK and
// shows its result as it leaves S_LOOK; a beat that refills goes on through S_MUL,
// S_SUM, S_DIV and S_UPD, forming the 64x32 product in two 32x32 partial products
// and dividing by 1e9 as a multiply by a reciprocal, and shows its result as it
// leaves S_UPD. in_tready rises together with out_tvalid.
// Write-back finishes before the next read, so same-bucket beats need no forwarding.
// Reset: a clearing pass over all NUM_BUCKETS words marks every bucket unused; no beat
// is accepted meanwhile. Stall: the result waits in the output register while the
// next beat is accepted and worked on; the block holds at its decision point
// until that register is free.
module token_bucket_rate_limiter_core
  import tbrl_pkg::*;
#(
  parameter int NUM_BUCKETS = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // bucket_index[9:0], now_ns[73:10], rate_pps[105:74], burst_size[137:106],
  // block_time_ns[201:138], zero[207:202]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // limited[0], outcome[3:1], zero[7:4]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(NUM_BUCKETS);

  // Bucket table
  entry_t mem [NUM_BUCKETS];

  state_t state_r, state_nxt;

  logic [AW-1:0]        clr_addr_r;
  logic [9:0]           idx_r;
  logic [AW-1:0]        addr_r;
  logic [63:0]          now_r;
  logic [31:0]          rate_r;
  logic [31:0]          burst_r;
  logic [63:0]          block_r;
  entry_t               rd_r;
  logic [63:0]          elapsed_r;
  logic [63:0]          pp_lo_r;
  logic [31:0]          pp_hi_r;
  logic [Y_W-1:0]       y_r;
  logic [63:0]          rp_ll_r;
  logic [55:0]          rp_lh_r;
  logic [54:0]          rp_hl_r;
  logic [46:0]          rp_hh_r;
  logic [56:0]          rp_mid_r;
  logic [QUO_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                 out_tvalid_r;
  logic                 out_limited_r;
  outcome_t             out_outcome_r;

  logic            slot_free;
  logic            clr_last;
  logic            div_last;
  logic            disabled;
  logic            blocked;
  logic            early;
  logic [9:0]      idx_red;
  logic [AW-1:0]   addr_cur;
  logic [63:0]     prod;
  logic [47:0]     quo_sum;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;
  logic            res_load;
  logic            res_limited;
  outcome_t        res_outcome;

  // Five steps of index reduction modulo NUM_BUCKETS, from shift top down
  function automatic logic [9:0] mod_steps(input logic [9:0] v, input int top);
    logic [9:0]  r;
    logic [30:0] m;
    r = v;
    for (int j = 0; j < 5; j++) begin
      m = 31'(NUM_BUCKETS) << (top - j);
      if ({21'b0, r} >= m) begin
        r = 10'({21'b0, r} - m);
      end
    end
    return r;
  endfunction

  assign slot_free = !out_tvalid_r || out_tready;
  assign clr_last  = (clr_addr_r == AW'(NUM_BUCKETS - 1));
  assign div_last  = (div_cnt_r == DIV_CNT_W'(DIV_CYCLES - 1));
  assign disabled  = (rate_r == 32'd0) || (burst_r == 32'd0);
  assign blocked   = (block_r != 64'd0) && (rd_r.blocked_until > now_r);
  assign early     = disabled || !rd_r.valid || blocked;
  assign idx_red   = mod_steps(idx_r, 4);
  assign addr_cur  = AW'(idx_red);
  assign prod      = pp_lo_r + {pp_hi_r, 32'd0};

  // Upper bits of the reciprocal product: bits 64 and up, quotient from bit 76
  assign quo_sum   = {23'd0, rp_mid_r[56:32]} + {1'b0, rp_hh_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_ADDR;
      end
      S_ADDR: state_nxt = S_LOOK;
      S_LOOK: begin
        if (!early) begin
          state_nxt = S_MUL;
        end else if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_MUL: state_nxt = S_SUM;
      S_SUM: state_nxt = S_DIV;
      S_DIV: begin
        if (div_last) state_nxt = S_UPD;
      end
      S_UPD: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Outputs: handshake, write-back and result
  always_comb begin
    logic [31:0] tokens;
    logic [31:0] room;
    logic [31:0] tok_new;
    logic [63:0] last_new;
    in_tready   = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = addr_r;
    wr_data     = rd_r;
    res_load    = 1'b0;
    res_limited = 1'b0;
    res_outcome = OUT_CONSUMED;
    tokens      = rd_r.tokens;
    room        = burst_r - tokens;
    tok_new     = tokens;
    last_new    = rd_r.last_refill;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
      end
      S_IDLE: in_tready = 1'b1;
      S_LOOK: begin
        res_load = early && slot_free;
        if (disabled) begin
          res_outcome = OUT_DISABLED;
        end else if (!rd_r.valid) begin
          res_outcome           = OUT_NEW;
          wr_en                 = slot_free;
          wr_data.valid         = 1'b1;
          wr_data.tokens        = burst_r - 32'd1;
          wr_data.last_refill   = now_r;
          wr_data.blocked_until = 64'd0;
        end else begin
          res_limited = 1'b1;
          res_outcome = OUT_BLOCKED;
        end
      end
      S_UPD: begin
        res_load = slot_free;
        wr_en    = slot_free;
        if (quo_r != '0) begin
          if ((tokens >= burst_r) || (quo_r >= {4'b0, room})) begin
            tok_new = burst_r;
          end else begin
            tok_new = tokens + quo_r[31:0];
          end
          last_new = now_r;
        end
        wr_data.last_refill = last_new;
        if (tok_new == 32'd0) begin
          res_limited    = 1'b1;
          res_outcome    = OUT_EMPTY;
          wr_data.tokens = tok_new;
          if (block_r != 64'd0) begin
            wr_data.blocked_until = now_r + block_r;
          end
        end else begin
          wr_data.tokens = tok_new - 32'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Bucket memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state_r == S_ADDR) begin
      rd_r <= mem[addr_cur];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      div_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (state_r == S_DIV) begin
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end else begin
        div_cnt_r <= '0;
      end
      if (res_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath: hold the beat, form the product, divide by reciprocal multiply
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      idx_r   <= mod_steps(in_tdata[9:0], 9);
      now_r   <= in_tdata[73:10];
      rate_r  <= in_tdata[105:74];
      burst_r <= in_tdata[137:106];
      block_r <= in_tdata[201:138];
    end
    if (state_r == S_ADDR) begin
      addr_r <= addr_cur;
    end
    if (state_r == S_LOOK) begin
      elapsed_r <= now_r - rd_r.last_refill;
    end
    if (state_r == S_MUL) begin
      pp_lo_r <= {32'd0, elapsed_r[31:0]} * {32'd0, rate_r};
      pp_hi_r <= 32'(elapsed_r[63:32] * rate_r);
    end
    if (state_r == S_SUM) begin
      y_r <= prod[63:PRE_SH];
    end
    if (state_r == S_DIV) begin
      case (div_cnt_r)
        DIV_CNT_W'(0): begin
          rp_ll_r <= {32'd0, y_r[31:0]} * {32'd0, RECIP[31:0]};
          rp_lh_r <= {24'd0, y_r[31:0]} * {32'd0, RECIP[55:32]};
        end
        DIV_CNT_W'(1): begin
          rp_hl_r <= {32'd0, y_r[Y_W-1:32]} * {23'd0, RECIP[31:0]};
          rp_hh_r <= {24'd0, y_r[Y_W-1:32]} * {23'd0, RECIP[55:32]};
        end
        DIV_CNT_W'(2): begin
          // Middle column: carries out of the low word plus both cross products
          rp_mid_r <= {25'd0, rp_ll_r[63:32]} + {1'b0, rp_lh_r} + {2'd0, rp_hl_r};
        end
        default: begin
          quo_r <= quo_sum[47:12];
        end
      endcase
    end
    if (res_load) begin
      out_limited_r <= res_limited;
      out_outcome_r <= res_outcome;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0, out_outcome_r, out_limited_r};

endmodule

FILE: sim/tb.sv
// Self-checking bench for the token bucket policer: shaped random traffic, scoreboard.
`timescale 1ns / 100ps

typedef struct packed {
  logic [63:0] block_time_ns;
  logic [31:0] burst_size;
  logic [31:0] rate_pps;
  logic [63:0] now_ns;
  logic [9:0]  bucket_index;
} bucket_req_t;

typedef struct {
  bit                  limited;
  tbrl_pkg::outcome_t  outcome;
} verdict_t;

// Mirrors the bucket table and queues one verdict per accepted request.
class policer_scoreboard;
  localparam int          NUM_SLOTS = 1024;
  localparam bit [63:0]   NS_PER_S  = 64'd1000000000;

  bit        used       [NUM_SLOTS];
  bit [31:0] tokens     [NUM_SLOTS];
  bit [63:0] stamp      [NUM_SLOTS];
  bit [63:0] hold_until [NUM_SLOTS];
  verdict_t  awaited    [$];
  int unsigned errors;

  function new();
    foreach (used[i]) begin
      used[i] = 1'b0;
    end
    errors = 0;
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  function verdict_t police(bucket_req_t r);
    verdict_t    v;
    bit [63:0]   rate64, burst64, elapsed, product, refill, tok;
    int unsigned slot;
    rate64    = {32'd0, r.rate_pps};
    burst64   = {32'd0, r.burst_size};
    slot      = r.bucket_index % NUM_SLOTS;
    v.limited = 1'b0;
    if (rate64 == 0 || burst64 == 0) begin
      v.outcome = tbrl_pkg::OUT_DISABLED;
      return v;
    end
    if (!used[slot]) begin
      used[slot]       = 1'b1;
      tokens[slot]     = r.burst_size - 32'd1;
      stamp[slot]      = r.now_ns;
      hold_until[slot] = 64'd0;
      v.outcome        = tbrl_pkg::OUT_NEW;
      return v;
    end
    // The block window only counts when this request carries a block time
    if (r.block_time_ns != 0 && hold_until[slot] > r.now_ns) begin
      v.limited = 1'b1;
      v.outcome = tbrl_pkg::OUT_BLOCKED;
      return v;
    end
    // Elapsed time and product both wrap at 64 bits before the divide
    elapsed = r.now_ns - stamp[slot];
    product = elapsed * rate64;
    refill  = product / NS_PER_S;
    tok     = {32'd0, tokens[slot]};
    if (refill != 0) begin
      if (tok >= burst64 || refill >= burst64 - tok) begin
        tok = burst64;
      end else begin
        tok = tok + refill;
      end
      stamp[slot] = r.now_ns;
    end
    if (tok == 0) begin
      if (r.block_time_ns != 0) begin
        hold_until[slot] = r.now_ns + r.block_time_ns;
      end
      v.limited = 1'b1;
      v.outcome = tbrl_pkg::OUT_EMPTY;
      return v;
    end
    tokens[slot] = tok[31:0] - 32'd1;
    v.outcome    = tbrl_pkg::OUT_CONSUMED;
    return v;
  endfunction

  function void note_request(bucket_req_t r);
    awaited.push_back(police(r));
  endfunction

  task report(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  task check_verdict(logic [7:0] beat);
    verdict_t want;
    if (awaited.size() == 0) begin
      report($sformatf("verdict beat %h with none pending", beat));
      return;
    end
    want = awaited.pop_front();
    if (beat[0] !== want.limited) begin
      report($sformatf("limited %b, want %b", beat[0], want.limited));
    end
    if (beat[3:1] !== want.outcome) begin
      report($sformatf("outcome %0d, want %0d", beat[3:1], want.outcome));
    end
  endtask
endclass

module tb
  import tbrl_pkg::*;
();

  localparam int          HOT_SLOTS   = 6;
  localparam int          NUM_PHASES  = 8;
  localparam int          PHASE_BEATS = 182;
  localparam int          TAIL_CYCLES = 40;
  // Clearing pass plus the longest stall stretch, with a wide margin
  localparam int unsigned STALL_LIMIT = 6000;
  localparam logic [63:0] MAX64       = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] MAX32       = 32'hFFFF_FFFF;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  policer_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned quiet_cycles  = 0;
  logic [63:0] wall_ns       = 64'd0;
  logic [9:0]  hot_pool [HOT_SLOTS];

  token_bucket_rate_limiter_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Receiver: stall at random per cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every accepted verdict beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_verdict(out_tdata);
    end
  end

  // Watchdog: give up when neither side moves a beat for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic bucket_req_t mk_req(logic [9:0] idx, logic [63:0] now,
                                         logic [31:0] rate, logic [31:0] burst,
                                         logic [63:0] block);
    bucket_req_t r;
    r.bucket_index  = idx;
    r.now_ns        = now;
    r.rate_pps      = rate;
    r.burst_size    = burst;
    r.block_time_ns = block;
    return r;
  endfunction

  // Drive one request beat; valid stays high after acceptance unless a gap follows
  task automatic send_request(bucket_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, r};
    do @(posedge clk); while (!in_tready);
    sb.note_request(r);
  endtask

  // Hold the sender until every pending verdict is back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly hot buckets with small time steps and small bursts, so buckets
  // drain, block and refill; the rest is full-range noise and disabled requests.
  task automatic make_request(output bucket_req_t r);
    int unsigned pick, k;
    logic [63:0] delta;
    pick = $urandom_range(99);
    r = mk_req(10'($urandom_range(1023)), {$urandom, $urandom}, $urandom, $urandom,
               {$urandom, $urandom});
    if (pick < 8) begin
      if ($urandom_range(1)) r.rate_pps = 32'd0;
      else r.burst_size = 32'd0;
    end else if (pick >= 20) begin
      if (pick >= 30) r.bucket_index = hot_pool[$urandom_range(HOT_SLOTS - 1)];
      k = $urandom_range(99);
      if (k < 25) delta = 64'd0;
      else if (k < 55) delta = 64'($urandom_range(1, 2000));
      else if (k < 80) delta = {32'd0, $urandom};
      else delta = {$urandom, $urandom};
      if (k >= 92) begin
        // step back in time; elapsed wraps
        r.now_ns = wall_ns - 64'($urandom_range(1, 1000000));
      end else begin
        r.now_ns = wall_ns + delta;
        wall_ns  = r.now_ns;
      end
      k = $urandom_range(99);
      if (k < 40) r.rate_pps = $urandom_range(1, 4);
      else if (k < 70) r.rate_pps = $urandom_range(1, 2000);
      else if (k < 90) r.rate_pps = $urandom_range(1, 1000000);
      k = $urandom_range(99);
      if (k < 50) r.burst_size = $urandom_range(1, 3);
      else if (k < 80) r.burst_size = $urandom_range(1, 100);
      k = $urandom_range(99);
      if (k < 35) r.block_time_ns = 64'd0;
      else if (k < 75) r.block_time_ns = 64'($urandom_range(1, 2000000000));
      else if (k < 90) r.block_time_ns = 64'($urandom_range(1, 2000));
    end
  endtask

  initial begin
    bucket_req_t req;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: disabled limiting, creation, empty, block window, wraps, burst cut
    send_request(mk_req(10'd0, 64'd0, 32'd0, 32'd5, 64'd0));
    send_request(mk_req(10'd0, 64'd0, 32'd5, 32'd0, 64'd0));
    send_request(mk_req(10'd1023, 64'd0, 32'd1, 32'd1, 64'd0));
    send_request(mk_req(10'd1023, 64'd0, 32'd1, 32'd1, 64'd0));
    send_request(mk_req(10'd1023, 64'd5, 32'd1, 32'd1, 64'd100));
    send_request(mk_req(10'd1023, 64'd50, 32'd1, 32'd1, 64'd1));
    // window ignored without a block time
    send_request(mk_req(10'd1023, 64'd50, 32'd1, 32'd1, 64'd0));
    send_request(mk_req(10'd1023, 64'd1000000000, 32'd1, 32'd1, 64'd1));
    send_request(mk_req(10'd0, MAX64, MAX32, MAX32, MAX64));
    send_request(mk_req(10'd0, MAX64, MAX32, MAX32, MAX64));
    // elapsed wraps to one, refill saturates at burst
    send_request(mk_req(10'd0, 64'd0, MAX32, MAX32, MAX64));
    // product wraps at 64 bits
    send_request(mk_req(10'd5, 64'd0, MAX32, 32'd2, 64'd0));
    send_request(mk_req(10'd5, 64'h8000_0000_0000_0000, MAX32, 32'd2, 64'd0));
    // stored count above a smaller burst: kept without refill, cut with refill
    send_request(mk_req(10'd6, 64'd100, 32'd1000, 32'd100, 64'd0));
    send_request(mk_req(10'd6, 64'd100, 32'd1000, 32'd10, 64'd0));
    send_request(mk_req(10'd6, 64'd1000100, 32'd1000, 32'd10, 64'd0));
    // block deadline wraps past the top of time
    send_request(mk_req(10'd7, MAX64 - 10, 32'd1, 32'd1, 64'd0));
    send_request(mk_req(10'd7, MAX64 - 10, 32'd1, 32'd1, 64'd20));
    send_request(mk_req(10'd7, MAX64 - 5, 32'd1, 32'd1, 64'd1));
    send_request(mk_req(10'd7, MAX64 - 6, 32'd1, 32'd1, 64'd1));
    send_request(mk_req(10'h155, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                        64'hAAAA_AAAA_AAAA_AAAA));
    send_request(mk_req(10'h155, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                        64'h5555_5555_5555_5555));
    send_request(mk_req(10'h2AA, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                        64'h5555_5555_5555_5555));
    drain();

    // Random phases, cycling through the idle and stall mixes
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 57; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      foreach (hot_pool[i]) hot_pool[i] = 10'($urandom_range(1023));
      if (p % 3 == 2) wall_ns = {$urandom, $urandom};
      for (int n = 0; n < PHASE_BEATS; n++) begin
        make_request(req);
        send_request(req);
      end
      drain();
    end

    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tbrl_pkg.sv
rtl/token_bucket_rate_limiter_core.sv
sim/tb.sv
